/* sv/pia_pkg.sv */
// Package for the positional insert/erase array: sizing constants, field widths,
// operation and status codes, and the decoded-command type shared by the modules.
// No dependencies.
package pia_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // Fixed widths of the item fields.
  localparam int OPC_W  = 3;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int ECNT_W = 5;

  // Internal widths that follow the capacity.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [IDX_W-1:0]      index_t;

  typedef enum logic [OPC_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_ERASE  = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_READ   = 3'd4,
    OP_FRONT  = 3'd5,
    OP_BACK   = 3'd6
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // What one storage cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_mode_t;

  // Decoded command from the controller to the array and the result register.
  typedef struct packed {
    logic    wr;        // place the new word at 'at', later entries move up
    logic    del;       // remove the entry at 'at', later entries move down
    index_t  at;
    logic    rd_en;     // the result carries the word at rd_addr
    index_t  rd_addr;
    status_t status;
    count_t  cnt_nxt;
  } pia_dec_t;

endpackage

/* sv/pia_ifs.sv */
// Handshake channel interfaces for the positional insert/erase array.
// Depends on pia_pkg for the field widths.
interface pia_in_if import pia_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface pia_out_if import pia_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  read_value;
  logic [STAT_W-1:0] status;
  logic [ECNT_W-1:0] element_count;

  modport source (output valid, read_value, status, element_count, input ready);
  modport sink   (input valid, read_value, status, element_count, output ready);
endinterface

/* sv/pia_cell.sv */
// One storage cell of the array: holds one word and can load a new word or take
// its left or right neighbor's word. Depends on pia_pkg.
module pia_cell import pia_pkg::*; (
  input  logic       clk,
  input  cell_mode_t mode,
  input  word_t      new_data,
  input  word_t      left_data,
  input  word_t      right_data,
  output word_t      data_q
);

  word_t data_r;
  word_t data_nxt;

  always_comb begin
    unique case (mode)
      CELL_LOAD:       data_nxt = new_data;
      CELL_FROM_LEFT:  data_nxt = left_data;
      CELL_FROM_RIGHT: data_nxt = right_data;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

/* sv/pia_ctrl.sv */
// Command decoder: checks an operation against the element count and produces
// the status, the new count and the shift/read controls. Depends on pia_pkg.
module pia_ctrl import pia_pkg::*; (
  input  logic [OPC_W-1:0] opcode,
  input  logic [POS_W-1:0] position,
  input  count_t           count,
  output pia_dec_t         dec
);

  always_comb begin
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic             full;
    logic             empty;

    pos_c = CMP_W'(position);
    cnt_c = CMP_W'(count);
    full  = (count == CNT_W'(CAPACITY));
    empty = (count == '0);

    dec         = '0;
    dec.status  = ST_OK;
    dec.cnt_nxt = count;

    unique case (opcode)
      OP_APPEND: begin
        if (full) begin
          dec.status = ST_FULL;
        end else begin
          dec.wr      = 1'b1;
          dec.at      = IDX_W'(count);
          dec.cnt_nxt = count + 1'b1;
        end
      end
      OP_INSERT: begin
        if (pos_c > cnt_c) begin
          dec.status = ST_RANGE;
        end else if (full) begin
          dec.status = ST_FULL;
        end else begin
          dec.wr      = 1'b1;
          dec.at      = IDX_W'(position);
          dec.cnt_nxt = count + 1'b1;
        end
      end
      OP_ERASE: begin
        if (pos_c >= cnt_c) begin
          dec.status = ST_RANGE;
        end else begin
          dec.del     = 1'b1;
          dec.at      = IDX_W'(position);
          dec.cnt_nxt = count - 1'b1;
        end
      end
      OP_CLEAR: begin
        dec.cnt_nxt = '0;
      end
      OP_READ: begin
        if (pos_c >= cnt_c) begin
          dec.status = ST_RANGE;
        end else begin
          dec.rd_en   = 1'b1;
          dec.rd_addr = IDX_W'(position);
        end
      end
      OP_FRONT: begin
        if (empty) begin
          dec.status = ST_EMPTY;
        end else begin
          dec.rd_en = 1'b1;
        end
      end
      OP_BACK: begin
        if (empty) begin
          dec.status = ST_EMPTY;
        end else begin
          dec.rd_en   = 1'b1;
          dec.rd_addr = IDX_W'(count - 1'b1);
        end
      end
      default: begin
        // The unused opcode is reported as out of range.
        dec.status = ST_RANGE;
      end
    endcase
  end

endmodule

/* sv/positional_insert_erase_array.sv */
// Top level of the positional insert/erase array: a chain of storage cells, the
// command decoder and the result register. Depends on pia_pkg, pia_ifs, pia_cell
// and pia_ctrl.

// The block keeps an ordered list of up to CAPACITY words in a row of cells, one
// word per cell, with the element count in a separate register. Every item is one
// operation (append, insert, erase, clear, read at an index, front or back) and
// produces exactly one result item holding the word read, a status and the
// element count after the operation. An insert or erase moves every later entry
// by one place at once, because each cell loads from its left or right
// neighbor in parallel, so each item is finished in the cycle it is accepted and
// its result appears in the result register on the next cycle. The block takes
// one item per cycle whenever the result side takes results as fast; the only
// thing that holds the input back is a result still waiting in the result
// register. Failed operations (full, out of range, empty, unused opcode) change
// neither the stored words nor the count. Clear only resets the count; the words
// themselves are left in place and are never visible again. Stored words need no
// clearing after reset, since reads only reach entries below the count.
module positional_insert_erase_array import pia_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  pia_in_if.sink     in_ch,
  pia_out_if.source  out_ch
);

  // Element count and handshake.
  count_t   count_r;
  count_t   count_nxt;
  logic     in_ready;
  logic     fire;
  pia_dec_t dec;

  // Result register.
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [VAL_W-1:0]  read_value_r;
  logic [VAL_W-1:0]  read_value_nxt;
  status_t           status_r;
  logic [ECNT_W-1:0] ecnt_r;

  // Cell chain.
  word_t      cell_q    [CAPACITY];
  cell_mode_t cell_mode [CAPACITY];
  word_t      new_word;
  word_t      rd_word;

  // A new item enters when the result register is empty or being emptied.
  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign fire        = in_ch.valid && in_ready;

  pia_ctrl u_ctrl (
    .opcode   (in_ch.opcode),
    .position (in_ch.position),
    .count    (count_r),
    .dec      (dec)
  );

  assign new_word = DATA_WIDTH'(in_ch.value);

  // Each cell decides from its own position how to move. On a write the cell at
  // the target loads the new word and every cell above it takes its left
  // neighbor; on an erase the target and every cell above it take the right
  // neighbor. Cells above the count may pick up stale words, which is harmless.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w;
    word_t right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_q[i+1];
    end

    always_comb begin
      cell_mode[i] = CELL_HOLD;
      if (fire && dec.wr) begin
        if (IDX_W'(i) == dec.at) begin
          cell_mode[i] = CELL_LOAD;
        end else if (IDX_W'(i) > dec.at) begin
          cell_mode[i] = CELL_FROM_LEFT;
        end
      end else if (fire && dec.del) begin
        if (IDX_W'(i) >= dec.at) begin
          cell_mode[i] = CELL_FROM_RIGHT;
        end
      end
    end

    pia_cell u_cell (
      .clk        (clk),
      .mode       (cell_mode[i]),
      .new_data   (new_word),
      .left_data  (left_w),
      .right_data (right_w),
      .data_q     (cell_q[i])
    );
  end

  // Single read port over the cells, addressed by the decoder.
  assign rd_word        = cell_q[dec.rd_addr];
  assign read_value_nxt = dec.rd_en ? VAL_W'(rd_word) : '0;

  assign count_nxt     = fire ? dec.cnt_nxt : count_r;
  assign out_valid_nxt = fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_value_r <= read_value_nxt;
      status_r     <= dec.status;
      ecnt_r       <= ECNT_W'(dec.cnt_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_value    = read_value_r;
  assign out_ch.status        = status_r;
  assign out_ch.element_count = ecnt_r;

`ifndef SYNTHESIS
  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  // A pending result always reports the current count.
  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ecnt_r == ECNT_W'(count_r))
    else $error("result count differs from stored count");

  // A successful write grows the count by one.
  a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && dec.wr |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("write did not grow the count");

  // A successful erase shrinks the count by one.
  a_erase_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && dec.del |=> count_r == CNT_W'($past(count_r) - 1'b1))
    else $error("erase did not shrink the count");

  // A full status is only reported when the array is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_FULL |-> count_r == CNT_W'(CAPACITY))
    else $error("full status with free entries");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for positional_insert_erase_array: named tests drive operation
// items through the input channel while a checker compares each result item with a predictor.
// Depends on pia_pkg, pia_ifs and the RTL of the block.
module tb_top;
  import pia_pkg::*;

  // Expected content of one result item.
  typedef struct {
    logic [VAL_W-1:0]  read_value;
    status_t           status;
    logic [ECNT_W-1:0] element_count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pia_in_if  in_ch ();
  pia_out_if out_ch ();

  positional_insert_erase_array i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The predictor keeps its own copy of the list. Entries at or above list_len
  // are stale and are never read, so they need no reset.
  word_t list_words [CAPACITY];
  int    list_len;

  // Results predicted for accepted items, oldest first.
  list_result_t awaited_results [$];

  int items_sent;
  int results_checked;
  int mismatch_count;
  int full_hits;
  int range_hits;
  int empty_hits;
  int peak_len;

  // Idling switches for the two sides, and a request for a long hold-off on
  // the result side that the pacing process counts down.
  bit src_idle_on;
  bit sink_idle_on;
  int hold_request;

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Applies one operation to the predicted list and returns the result it
  // should produce. A failed operation leaves the list as it was.
  function automatic list_result_t list_step(input logic [OPC_W-1:0] op,
                                             input logic [POS_W-1:0] pos,
                                             input logic [VAL_W-1:0] val);
    list_result_t res;
    int           p;
    p = int'(pos);
    res.read_value = '0;
    res.status     = ST_OK;
    case (opcode_t'(op))
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_len] = word_t'(val);
          list_len++;
        end
      end
      OP_INSERT: begin
        // The position check wins over the full check.
        if (p > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = word_t'(val);
          list_len++;
        end
      end
      OP_ERASE: begin
        if (p >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      OP_CLEAR: begin
        list_len = 0;
      end
      OP_READ: begin
        if (p >= list_len) res.status = ST_RANGE;
        else res.read_value = list_words[p];
      end
      OP_FRONT: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else res.read_value = list_words[0];
      end
      OP_BACK: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else res.read_value = list_words[list_len-1];
      end
      default: begin
        // The unused opcode is reported as out of range.
        res.status = ST_RANGE;
      end
    endcase
    case (res.status)
      ST_FULL:  full_hits++;
      ST_RANGE: range_hits++;
      ST_EMPTY: empty_hits++;
      default:  ;
    endcase
    if (list_len > peak_len) peak_len = list_len;
    res.element_count = ECNT_W'(list_len);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb_top: MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Sends one item. An optional gap comes first, with valid low; the item then
  // stays on the channel until the block takes it, and only then is its
  // result predicted, so the predictor follows the order of acceptance.
  task automatic send_item(input logic [OPC_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
    int           gap;
    list_result_t pred;
    gap = src_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.position <= pos;
    in_ch.value    <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pred = list_step(op, pos, val);
    awaited_results.insert(awaited_results.size(), pred);
    items_sent++;
  endtask

  // The sender pauses here until every predicted result has been checked.
  task automatic wait_for_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Draws one item. Most items are well formed for the current fill level, with
  // the mix tilted toward growing or shrinking the list; the rest are noise
  // over the whole field ranges, including the unused opcode.
  task automatic send_random_item(input int grow_pct);
    logic [OPC_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               r;
    val = $urandom;
    if ($urandom_range(0, 99) < 8) begin
      op  = OPC_W'($urandom_range(0, 7));
      pos = POS_W'($urandom_range(0, 31));
    end else begin
      r = $urandom_range(0, 99);
      if (r < grow_pct) begin
        op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
      end else if (r < grow_pct + 18) begin
        op = OP_ERASE;
      end else if (r < grow_pct + 20) begin
        op = OP_CLEAR;
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_READ;
          1:       op = OP_FRONT;
          default: op = OP_BACK;
        endcase
      end
      if (op == OP_INSERT) pos = POS_W'($urandom_range(0, list_len));
      else pos = (list_len > 0) ? POS_W'($urandom_range(0, list_len - 1)) : '0;
    end
    send_item(op, pos, val);
  endtask

  // Operations on an empty list: reads report empty or out of range, an erase and
  // an insert past the count are refused, and the unused opcode is rejected.
  task automatic test_empty_list();
    send_item(OP_FRONT, 5'd0, 32'h0);
    send_item(OP_BACK, 5'd0, 32'h0);
    send_item(OP_READ, 5'd0, 32'h0);
    send_item(OP_ERASE, 5'd31, 32'h0);
    send_item(OP_INSERT, 5'd1, 32'hDEAD_BEEF);
    send_item(3'd7, 5'd31, 32'hFFFF_FFFF);
    wait_for_drain();
  endtask

  // Fills the list to capacity: inserts at the front and at the end, then
  // appends with extreme and alternating bit patterns.
  task automatic test_fill_to_capacity();
    send_item(OP_INSERT, 5'd0, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 5'd1, 32'h0000_0000);
    for (int i = 2; i < CAPACITY; i++) begin
      send_item(OP_APPEND, 5'd0, (i % 2) ? 32'hAAAA_AAAA ^ i : 32'h5555_5555 ^ i);
    end
    wait_for_drain();
  endtask

  // Operations on a full list, followed by a clear that empties it.
  task automatic test_full_list();
    send_item(OP_APPEND, 5'd0, 32'h1234_5678);
    send_item(OP_INSERT, 5'd16, 32'h1234_5678);
    send_item(OP_INSERT, 5'd17, 32'h1234_5678);
    send_item(OP_READ, 5'd15, 32'h0);
    send_item(OP_ERASE, 5'd0, 32'h0);
    send_item(OP_INSERT, 5'd5, 32'hCAFE_F00D);
    send_item(OP_CLEAR, 5'd0, 32'h0);
    send_item(OP_FRONT, 5'd0, 32'h0);
    wait_for_drain();
  endtask

  // The result side holds off for a long stretch while the sender keeps
  // offering items back to back, so the block must stall its input.
  task automatic test_result_backpressure(input int n);
    src_idle_on  = 1'b0;
    hold_request = 80;
    for (int i = 0; i < n; i++) send_random_item(50);
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int n, input int grow_pct);
    for (int i = 0; i < n; i++) send_random_item(grow_pct);
    wait_for_drain();
  endtask

  // Result-side pacing: a requested hold-off first, then random stalls when
  // they are enabled. Ready is raised again before each new random stall.
  initial begin : result_pacing
    int stall_left;
    int hold_left;
    stall_left   = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_idle_on && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // Every accepted result is compared field by field with the oldest
  // prediction. Outputs are sampled at the rising edge, before the block's
  // registers update.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with none awaited: value %h status %0d count %0d",
                                  out_ch.read_value, out_ch.status, out_ch.element_count));
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (out_ch.read_value !== want.read_value)
          report_mismatch($sformatf("read_value: want %h got %h",
                                    want.read_value, out_ch.read_value));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status: want %0d got %0d", want.status, out_ch.status));
        if (out_ch.element_count !== want.element_count)
          report_mismatch($sformatf("element_count: want %0d got %0d",
                                    want.element_count, out_ch.element_count));
      end
    end
  end

  // Runs the tests in turn and reports the outcome.
  initial begin : test_sequence
    in_ch.valid    = 1'b0;
    in_ch.opcode   = '0;
    in_ch.position = '0;
    in_ch.value    = '0;
    list_len        = 0;
    items_sent      = 0;
    results_checked = 0;
    mismatch_count  = 0;
    full_hits       = 0;
    range_hits      = 0;
    empty_hits      = 0;
    peak_len        = 0;
    hold_request    = 0;
    src_idle_on     = 1'b1;
    sink_idle_on    = 1'b1;

    // Reset is held low from the start and released at a falling edge.
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_fill_to_capacity();
    test_full_list();
    test_result_backpressure(40);

    // Growing, shrinking and mixed traffic, with and without idling, so the
    // fill level sweeps the whole range and sits at both ends for a while.
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    test_random_traffic(120, 65);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random_traffic(120, 25);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    test_random_traffic(120, 45);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b1;
    test_random_traffic(120, 75);

    // Let any late result show up before the verdict.
    repeat (20) @(posedge clk);

    $display("tb_top: %0d items sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, mismatch_count);
    $display("tb_top: refused as full %0d, out of range %0d, empty %0d, peak fill %0d",
             full_hits, range_hits, empty_hits, peak_len);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #400000;
    $display("tb_top: timeout with %0d results outstanding", awaited_results.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
